/* rtl/eur_pkg.sv */
// Package for the Euler XYZ vector rotation block.
// Holds widths, pipeline depths, the arctangent table and shared types.
// No dependencies.
`default_nettype none

package eur_pkg;

    localparam int TRIG_STEPS = 16;
    localparam int STEP_W     = 5;
    localparam int COORD_W    = 32;
    localparam int ANG_W      = 16;
    localparam int TRIG_W     = 34;
    localparam int WIDE_W     = 34;
    localparam int PROD_W     = 2 * WIDE_W;

    localparam int PREP_LAT = 4;
    localparam int ROT_LAT  = 2;
    localparam int VEC_LAT  = PREP_LAT + TRIG_STEPS + 1;
    localparam int PIPE_LAT = VEC_LAT + 3 * ROT_LAT + 1;

    localparam logic signed [16:0] ANG_LIMIT   = 17'sd23040;
    localparam logic signed [16:0] ANG_HALF    = 17'sd11520;
    localparam logic signed [16:0] ANG_QUARTER = 17'sd5760;

    // pi in Q30 split as 11520 * HI + LO, so angle * pi / 11520 needs no divider
    localparam logic [31:0] PI_HI_MUL  = 32'd292817;
    localparam logic [25:0] PI_LO_MUL  = 26'd7586;
    localparam logic [25:0] PI_RND     = 26'd5760;
    localparam logic [52:0] RECIP_MUL  = 53'd95443718;
    localparam int          RECIP_SH   = 40;

    localparam logic signed [TRIG_W-1:0] GAIN_INV = 34'sd652032874;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    typedef logic signed [TRIG_W-1:0]  t_trig;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_trig x;
        t_trig y;
        t_trig z;
        logic  neg;
    } t_lane;

    typedef struct packed {
        t_trig c;
        t_trig s;
    } t_cs;

    typedef struct packed {
        t_coord x;
        t_coord y;
        t_coord z;
    } t_vec;

    function automatic t_trig atan_q30(input logic [STEP_W-1:0] idx);
        t_trig r;
        case (idx)
            5'd0:    r = 34'sd843314856;
            5'd1:    r = 34'sd497837829;
            5'd2:    r = 34'sd263043836;
            5'd3:    r = 34'sd133525158;
            5'd4:    r = 34'sd67021686;
            5'd5:    r = 34'sd33543515;
            5'd6:    r = 34'sd16775850;
            5'd7:    r = 34'sd8388437;
            5'd8:    r = 34'sd4194282;
            5'd9:    r = 34'sd2097149;
            5'd10:   r = 34'sd1048575;
            5'd11:   r = 34'sd524287;
            5'd12:   r = 34'sd262143;
            5'd13:   r = 34'sd131071;
            5'd14:   r = 34'sd65535;
            5'd15:   r = 34'sd32767;
            5'd16:   r = 34'sd16383;
            5'd17:   r = 34'sd8191;
            5'd18:   r = 34'sd4095;
            5'd19:   r = 34'sd2047;
            5'd20:   r = 34'sd1023;
            5'd21:   r = 34'sd511;
            5'd22:   r = 34'sd255;
            5'd23:   r = 34'sd127;
            default: r = '0;
        endcase
        return r;
    endfunction

    function automatic t_coord sat_coord(input t_wide v);
        t_coord r;
        if (v > t_wide'(COORD_MAX)) begin
            r = COORD_MAX;
        end else if (v < t_wide'(COORD_MIN)) begin
            r = COORD_MIN;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/eur_angle_prep.sv */
// Angle front end: clamps and folds a 1/64-degree angle into +/-90 degrees
// and converts it to a Q30 radian start lane for the CORDIC chain.
// Depends on eur_pkg.
`default_nettype none

module eur_angle_prep import eur_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_en,
    input  wire logic signed [ANG_W-1:0] i_angle,
    output t_lane                        o_lane
);

    logic signed [16:0] a_sat;
    logic signed [16:0] a_wrap;
    logic signed [16:0] a_fold;
    logic signed [16:0] a_abs;
    logic               fold_neg;

    logic [12:0] r_mag;
    logic        r_below_a, r_neg_a;
    logic [31:0] r_hi_b;
    logic [25:0] r_lo_b;
    logic        r_below_b, r_neg_b;
    logic [31:0] r_hi_c;
    logic [12:0] r_q_c;
    logic        r_below_c, r_neg_c;
    t_lane       r_lane;

    logic [52:0] lo_prod;
    logic [31:0] z_mag;

    always_comb begin
        a_sat = {i_angle[ANG_W-1], i_angle};
        if (a_sat > ANG_LIMIT) begin
            a_sat = ANG_LIMIT;
        end
        if (a_sat < -ANG_LIMIT) begin
            a_sat = -ANG_LIMIT;
        end
        a_wrap = a_sat;
        if (a_sat > ANG_HALF) begin
            a_wrap = a_sat - ANG_LIMIT;
        end
        if (a_sat < -ANG_HALF) begin
            a_wrap = a_sat + ANG_LIMIT;
        end
        // fold by half a turn flips sine and cosine
        a_fold   = a_wrap;
        fold_neg = 1'b0;
        if (a_wrap > ANG_QUARTER) begin
            a_fold   = a_wrap - ANG_HALF;
            fold_neg = 1'b1;
        end
        if (a_wrap < -ANG_QUARTER) begin
            a_fold   = a_wrap + ANG_HALF;
            fold_neg = 1'b1;
        end
        a_abs = a_fold[16] ? -a_fold : a_fold;
    end

    // floor(v / 11520) for v below 2^26 by rounded-up reciprocal
    assign lo_prod = {27'd0, r_lo_b} * RECIP_MUL;
    assign z_mag   = r_hi_c + {19'd0, r_q_c};

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag     <= a_abs[12:0];
            r_below_a <= a_fold[16];
            r_neg_a   <= fold_neg;

            r_hi_b    <= {19'd0, r_mag} * PI_HI_MUL;
            r_lo_b    <= {13'd0, r_mag} * PI_LO_MUL + PI_RND;
            r_below_b <= r_below_a;
            r_neg_b   <= r_neg_a;

            r_hi_c    <= r_hi_b;
            r_q_c     <= lo_prod[RECIP_SH+12:RECIP_SH];
            r_below_c <= r_below_b;
            r_neg_c   <= r_neg_b;

            r_lane.x   <= GAIN_INV;
            r_lane.y   <= '0;
            r_lane.z   <= r_below_c ? -t_trig'({2'b00, z_mag}) : t_trig'({2'b00, z_mag});
            r_lane.neg <= r_neg_c;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

/* rtl/eur_cordic_cell.sv */
// One rotation-mode CORDIC iteration, registered.
// Depends on eur_pkg for the lane type and the arctangent table.
`default_nettype none

module eur_cordic_cell import eur_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [STEP_W-1:0] i_step,
    input  t_lane                  i_lane,
    output t_lane                  o_lane
);

    t_trig x_in, y_in, z_in;
    t_trig x_sh, y_sh, ang;
    t_lane n_lane;
    t_lane r_lane;

    always_comb begin
        x_in = i_lane.x;
        y_in = i_lane.y;
        z_in = i_lane.z;
        x_sh = x_in >>> i_step;
        y_sh = y_in >>> i_step;
        ang  = atan_q30(i_step);
        n_lane.neg = i_lane.neg;
        if (!z_in[TRIG_W-1]) begin
            n_lane.x = x_in - y_sh;
            n_lane.y = y_in + x_sh;
            n_lane.z = z_in - ang;
        end else begin
            n_lane.x = x_in + y_sh;
            n_lane.y = y_in - x_sh;
            n_lane.z = z_in + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

`default_nettype wire

/* rtl/eur_rot_stage.sv */
// Plane rotation of two components: one = a*c - b*s, two = a*s + b*c,
// rounded half up from Q30. Multiply stage, then add and round stage.
// Depends on eur_pkg.
`default_nettype none

module eur_rot_stage import eur_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  t_wide     i_a,
    input  t_wide     i_b,
    input  t_wide     i_pass,
    input  t_cs       i_cs,
    output t_wide     o_one,
    output t_wide     o_two,
    output t_wide     o_pass
);

    localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W+1)'(64'sd536870912);

    logic signed [PROD_W-1:0] r_ac, r_bs, r_as, r_bc;
    t_wide                    r_pass1;
    logic signed [PROD_W:0]   sum_one, sum_two;
    logic signed [PROD_W:0]   sh_one, sh_two;
    t_wide                    r_one, r_two, r_pass2;

    always_comb begin
        sum_one = {r_ac[PROD_W-1], r_ac} - {r_bs[PROD_W-1], r_bs} + ROUND_HALF;
        sum_two = {r_as[PROD_W-1], r_as} + {r_bc[PROD_W-1], r_bc} + ROUND_HALF;
        sh_one  = sum_one >>> 30;
        sh_two  = sum_two >>> 30;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ac    <= i_a * i_cs.c;
            r_bs    <= i_b * i_cs.s;
            r_as    <= i_a * i_cs.s;
            r_bc    <= i_b * i_cs.c;
            r_pass1 <= i_pass;
            r_one   <= sh_one[WIDE_W-1:0];
            r_two   <= sh_two[WIDE_W-1:0];
            r_pass2 <= r_pass1;
        end
    end

    assign o_one  = r_one;
    assign o_two  = r_two;
    assign o_pass = r_pass2;

endmodule

`default_nettype wire

/* rtl/euler_xyz_vector_rotate_unit.sv */
// Euler XYZ rotation of a Q16.16 vector by three angles in 1/64 degree.
// Input channel: i_in_valid / o_in_ready carry vec_x/y/z and the three angles.
// Output channel: o_out_valid / i_out_ready carry rot_x/y/z, saturated to 32 bits.
// Throughput: one word per cycle while the output is not stalled. The pipeline
// runs through the angle front end, the CORDIC cell chain (one cell per step),
// the sign stage, three rotation stages and the output register.
// All three angles run through their own cell chains in parallel; the vector
// waits in a delay line and meets each sine/cosine pair at its rotation stage.
// The whole pipeline advances together: a stalled output word holds every
// stage, and o_in_ready drops while the output word waits.
// Reset (synchronous, active low) clears the valid bits only; words in flight
// are dropped. The block keeps no state between words.
// Depends on eur_pkg, eur_angle_prep, eur_cordic_cell, eur_rot_stage.
`default_nettype none

module euler_xyz_vector_rotate_unit import eur_pkg::*; (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_in_valid,
    output      logic                      o_in_ready,
    input  wire logic signed [COORD_W-1:0] i_vec_x,
    input  wire logic signed [COORD_W-1:0] i_vec_y,
    input  wire logic signed [COORD_W-1:0] i_vec_z,
    input  wire logic signed [ANG_W-1:0]   i_angle_about_x,
    input  wire logic signed [ANG_W-1:0]   i_angle_about_y,
    input  wire logic signed [ANG_W-1:0]   i_angle_about_z,
    output      logic                      o_out_valid,
    input  wire logic                      i_out_ready,
    output      logic signed [COORD_W-1:0] o_rot_x,
    output      logic signed [COORD_W-1:0] o_rot_y,
    output      logic signed [COORD_W-1:0] o_rot_z
);

    logic                    en;
    logic [PIPE_LAT-1:0]     r_vld;
    logic signed [ANG_W-1:0] w_ang  [3];
    t_lane                   w_lane [3][TRIG_STEPS+1];
    t_cs                     r_cs   [3];
    t_cs                     r_cs_y [2];
    t_cs                     r_cs_z [4];
    t_vec                    r_vec  [VEC_LAT];

    t_wide rx_one, rx_two, rx_pass;
    t_wide ry_one, ry_two, ry_pass;
    t_wide rz_one, rz_two, rz_pass;

    t_coord r_rot_x, r_rot_y, r_rot_z;

    assign en          = !r_vld[PIPE_LAT-1] || i_out_ready;
    assign o_in_ready  = en;
    assign o_out_valid = r_vld[PIPE_LAT-1];

    assign w_ang[0] = i_angle_about_x;
    assign w_ang[1] = i_angle_about_y;
    assign w_ang[2] = i_angle_about_z;

    for (genvar g = 0; g < 3; g++) begin : g_axis
        eur_angle_prep u_prep (
            .i_clk   (i_clk),
            .i_en    (en),
            .i_angle (w_ang[g]),
            .o_lane  (w_lane[g][0])
        );
        for (genvar k = 0; k < TRIG_STEPS; k++) begin : g_cell
            eur_cordic_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (en),
                .i_step (STEP_W'(k)),
                .i_lane (w_lane[g][k]),
                .o_lane (w_lane[g][k+1])
            );
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cs[g].c <= w_lane[g][TRIG_STEPS].neg ? -w_lane[g][TRIG_STEPS].x
                                                       :  w_lane[g][TRIG_STEPS].x;
                r_cs[g].s <= w_lane[g][TRIG_STEPS].neg ? -w_lane[g][TRIG_STEPS].y
                                                       :  w_lane[g][TRIG_STEPS].y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[PIPE_LAT-2:0], i_in_valid};
        end
    end

    // delay lines: vector waits for the trig chain, later angles wait for earlier stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vec[0] <= '{x: i_vec_x, y: i_vec_y, z: i_vec_z};
            for (int i = 1; i < VEC_LAT; i++) begin
                r_vec[i] <= r_vec[i-1];
            end
            r_cs_y[0] <= r_cs[1];
            r_cs_y[1] <= r_cs_y[0];
            r_cs_z[0] <= r_cs[2];
            for (int i = 1; i < 4; i++) begin
                r_cs_z[i] <= r_cs_z[i-1];
            end
        end
    end

    // about X: y' = y c - z s, z' = y s + z c
    eur_rot_stage u_rot_x (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (t_wide'(r_vec[VEC_LAT-1].y)),
        .i_b    (t_wide'(r_vec[VEC_LAT-1].z)),
        .i_pass (t_wide'(r_vec[VEC_LAT-1].x)),
        .i_cs   (r_cs[0]),
        .o_one  (rx_one),
        .o_two  (rx_two),
        .o_pass (rx_pass)
    );

    // about Y: z' = z c - x s, x' = z s + x c
    eur_rot_stage u_rot_y (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (rx_two),
        .i_b    (rx_pass),
        .i_pass (rx_one),
        .i_cs   (r_cs_y[1]),
        .o_one  (ry_one),
        .o_two  (ry_two),
        .o_pass (ry_pass)
    );

    // about Z: x' = x c - y s, y' = x s + y c
    eur_rot_stage u_rot_z (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (ry_two),
        .i_b    (ry_pass),
        .i_pass (ry_one),
        .i_cs   (r_cs_z[3]),
        .o_one  (rz_one),
        .o_two  (rz_two),
        .o_pass (rz_pass)
    );

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rot_x <= sat_coord(rz_one);
            r_rot_y <= sat_coord(rz_two);
            r_rot_z <= sat_coord(rz_pass);
        end
    end

    assign o_rot_x = r_rot_x;
    assign o_rot_y = r_rot_y;
    assign o_rot_z = r_rot_z;

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output word valid right after reset");
    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input taken while output word stalled");
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> r_vld[0])
        else $error("accepted word missing from pipeline");
`endif

endmodule

`default_nettype wire
